/* rtl/core/crce_pkg.sv */
// ----------------------------------------------------------------------------
// crce_pkg: shared types and helpers for the configurable CRC engine
// Holds the configuration bundle, register indexes and bit reversal helpers.
// ----------------------------------------------------------------------------
package crce_pkg;

	// Register indexes on the configuration write port
	localparam logic [2:0] REG_CRC_WIDTH      = 3'd0;
	localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [2:0] REG_INITIAL_VALUE  = 3'd2;
	localparam logic [2:0] REG_REFLECT_INPUT  = 3'd3;
	localparam logic [2:0] REG_REFLECT_OUTPUT = 3'd4;
	localparam logic [2:0] REG_FINAL_XOR      = 3'd5;

	// Reset values (standard CRC-32)
	localparam logic [5:0]  RST_CRC_WIDTH      = 6'd32;
	localparam logic [31:0] RST_POLYNOMIAL     = 32'h04C1_1DB7;
	localparam logic [31:0] RST_INITIAL_VALUE  = 32'hFFFF_FFFF;
	localparam logic        RST_REFLECT_INPUT  = 1'b1;
	localparam logic        RST_REFLECT_OUTPUT = 1'b1;
	localparam logic [31:0] RST_FINAL_XOR      = 32'hFFFF_FFFF;

	// Width limits of the CRC register
	localparam logic [5:0] MIN_WIDTH = 6'd4;
	localparam logic [5:0] MAX_WIDTH = 6'd32;

	typedef struct packed {
		logic [5:0]  crc_width;
		logic [31:0] polynomial;
		logic [31:0] initial_value;
		logic        reflect_input;
		logic        reflect_output;
		logic [31:0] final_xor;
	} crce_cfg_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [31:0] reverse32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = v[31-i];
		end
		return r;
	endfunction

endpackage

/* rtl/core/crce_in_if.sv */
// ----------------------------------------------------------------------------
// crce_in_if: message byte channel
// Valid/ready channel carrying one message byte with start and end flags.
// ----------------------------------------------------------------------------
interface crce_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_message;
	logic       end_of_message;

	modport source (
		output valid, data_byte, start_of_message, end_of_message,
		input  ready
	);
	modport sink (
		input  valid, data_byte, start_of_message, end_of_message,
		output ready
	);
endinterface

/* rtl/core/crce_out_if.sv */
// ----------------------------------------------------------------------------
// crce_out_if: CRC result channel
// Valid/ready channel carrying one finished CRC value.
// ----------------------------------------------------------------------------
interface crce_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_result;

	modport source (
		output valid, crc_result,
		input  ready
	);
	modport sink (
		input  valid, crc_result,
		output ready
	);
endinterface

/* rtl/core/crce_cfg_regs.sv */
// ----------------------------------------------------------------------------
// crce_cfg_regs: configuration register file
// Write-only registers selected by index; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module crce_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	output crce_pkg::crce_cfg_t cfg
);
	import crce_pkg::*;

	crce_cfg_t cfg_q;

	// Write the selected register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_width      <= RST_CRC_WIDTH;
			cfg_q.polynomial     <= RST_POLYNOMIAL;
			cfg_q.initial_value  <= RST_INITIAL_VALUE;
			cfg_q.reflect_input  <= RST_REFLECT_INPUT;
			cfg_q.reflect_output <= RST_REFLECT_OUTPUT;
			cfg_q.final_xor      <= RST_FINAL_XOR;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_CRC_WIDTH:      cfg_q.crc_width      <= cfg_data[5:0];
				REG_POLYNOMIAL:     cfg_q.polynomial     <= cfg_data;
				REG_INITIAL_VALUE:  cfg_q.initial_value  <= cfg_data;
				REG_REFLECT_INPUT:  cfg_q.reflect_input  <= cfg_data[0];
				REG_REFLECT_OUTPUT: cfg_q.reflect_output <= cfg_data[0];
				REG_FINAL_XOR:      cfg_q.final_xor      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/crce_fold.sv */
// ----------------------------------------------------------------------------
// crce_fold: one-byte CRC update
// Folds a byte into the register over eight polynomial steps, with the
// register aligned to bit 31 so the feedback tap is fixed; also forms the
// finished result (output reflection and final XOR).
// ----------------------------------------------------------------------------
module crce_fold (
	input  crce_pkg::crce_cfg_t cfg,
	input  logic [31:0]         crc_cur,
	input  logic [7:0]          data_byte,
	input  logic                start_of_message,
	output logic [31:0]         crc_next,
	output logic [31:0]         crc_result
);
	import crce_pkg::*;

	logic [5:0]  eff_width;
	logic [4:0]  align_sh;
	logic [5:0]  align_full;
	logic [31:0] mask;
	logic [31:0] base;
	logic [31:0] apoly;
	logic [31:0] areg;
	logic [7:0]  byte_in;
	logic [31:0] res_raw;
	logic        fb;

	// Clamp width and derive alignment shift and mask
	always_comb begin
		if (cfg.crc_width < MIN_WIDTH) begin
			eff_width = MIN_WIDTH;
		end else if (cfg.crc_width > MAX_WIDTH) begin
			eff_width = MAX_WIDTH;
		end else begin
			eff_width = cfg.crc_width;
		end
		align_full = MAX_WIDTH - eff_width;
		align_sh   = align_full[4:0];
		mask       = 32'hFFFF_FFFF >> align_sh;
	end

	// Eight MSB-first polynomial steps on the left-aligned register
	always_comb begin
		base    = start_of_message ? cfg.initial_value : crc_cur;
		byte_in = cfg.reflect_input ? reverse8(data_byte) : data_byte;
		apoly   = cfg.polynomial << align_sh;
		areg    = base << align_sh;
		fb      = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			fb   = areg[31] ^ byte_in[i];
			areg = {areg[30:0], 1'b0} ^ (fb ? apoly : 32'd0);
		end
		crc_next = areg >> align_sh;
	end

	// Reflect over the width (a full reverse of the aligned word) and XOR
	always_comb begin
		res_raw    = cfg.reflect_output ? reverse32(areg) : crc_next;
		crc_result = (res_raw ^ cfg.final_xor) & mask;
	end

endmodule

/* rtl/core/configurable_crc_engine.sv */
// ----------------------------------------------------------------------------
// configurable_crc_engine: byte-serial parameterized CRC engine
//
// Usage:
//   data_chan carries one message byte per request with start/end flags.
//   A start flag loads initial_value before the byte is folded in; an end
//   flag makes the finished CRC appear as one request on result_chan.
//   Width (4..32), polynomial, initial value, input/output reflection and
//   final XOR come from the write-only configuration port (cfg_wen,
//   cfg_idx, cfg_data); write it only while the engine is idle.
//   Throughput: one byte per cycle while no end byte waits on a stalled
//   result. The eight polynomial steps of a byte run combinationally
//   between the input stage register and the CRC and result registers,
//   so the CRC register is ready for the next byte. An end byte passes
//   through the input stage register and then the result register.
//   Reset loads the CRC-32 configuration and sets the CRC register to all
//   ones; the input stage and result register come up empty.
//   When result_chan stalls, the result holds; bytes without an end flag
//   keep flowing, and the next end byte waits in the input stage, which
//   drops data_chan.ready until the result is taken.
// ----------------------------------------------------------------------------
module configurable_crc_engine (
	input  logic        clk,
	input  logic        arst_n,
	crce_in_if.sink     data_chan,
	crce_out_if.source  result_chan,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import crce_pkg::*;

	crce_cfg_t   cfg;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        sop_s1;
	logic        eom_s1;
	logic [31:0] crc_q;
	logic        res_valid_q;
	logic [31:0] res_q;
	logic [31:0] crc_next;
	logic [31:0] crc_fin;
	logic        out_free;
	logic        fold_go;
	logic        accept;

	crce_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	crce_fold u_fold (
		.cfg              (cfg),
		.crc_cur          (crc_q),
		.data_byte        (data_s1),
		.start_of_message (sop_s1),
		.crc_next         (crc_next),
		.crc_result       (crc_fin)
	);

	// Handshake: fold a held byte unless it is an end byte and the result slot is full
	assign out_free        = !res_valid_q || result_chan.ready;
	assign fold_go         = valid_s1 && (!eom_s1 || out_free);
	assign data_chan.ready = !valid_s1 || fold_go;
	assign accept          = data_chan.valid && data_chan.ready;

	// Input stage: hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fold_go);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_chan.data_byte;
			sop_s1  <= data_chan.start_of_message;
			eom_s1  <= data_chan.end_of_message;
		end
	end

	// Advance the CRC register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= RST_INITIAL_VALUE;
		end else if (fold_go) begin
			crc_q <= crc_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (fold_go && eom_s1) || (res_valid_q && !result_chan.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fold_go && eom_s1) begin
			res_q <= crc_fin;
		end
	end

	assign result_chan.valid      = res_valid_q;
	assign result_chan.crc_result = res_q;

endmodule

/* rtl/core/crce_checker.sv */
// ----------------------------------------------------------------------------
// crce_checker: port-level checks for the CRC engine
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module crce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_eom,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] crc_result
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crc_result))
		else $error("stalled result changed or dropped");

	// Never stall input while the result slot is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// A fresh result traces back to an accepted end byte through the input stage and result registers
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_eom, 2))
		else $error("result without a matching end byte");

endmodule

bind configurable_crc_engine crce_checker u_crce_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (data_chan.valid),
	.in_ready   (data_chan.ready),
	.in_eom     (data_chan.end_of_message),
	.out_valid  (result_chan.valid),
	.out_ready  (result_chan.ready),
	.crc_result (result_chan.crc_result)
);
